>>> src/smnr_pkg.sv
// ----------------------------------------------------------------------------
// smnr_pkg - shared types and constants
// Registry depth, command and mode codes, status codes, token and write types,
// and the mode transition table of the supervisor.
// ----------------------------------------------------------------------------
package smnr_pkg;

   localparam int MAX_NODES = 32;
   localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W     = $clog2(MAX_NODES + 1);

   localparam int ID_W     = 32;
   localparam int KIND_W   = 4;
   localparam int ONLINE_W = 7;
   localparam int RCOUNT_W = 6;

   typedef enum logic [2:0] {
      CMD_REGISTER = 3'd0,
      CMD_SET_MODE = 3'd1,
      CMD_ACTIVATE = 3'd2,
      CMD_HEALTH   = 3'd3,
      CMD_SHUTDOWN = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_INIT     = 3'd0,
      MODE_RUN      = 3'd1,
      MODE_HOLD     = 3'd2,
      MODE_SHUTDOWN = 3'd3,
      MODE_FAILOVER = 3'd4,
      MODE_ESTOP    = 3'd5,
      MODE_MAINT    = 3'd6,
      MODE_SIM      = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_REJECTED  = 2'd1,
      ST_NO_NODES  = 2'd2,
      ST_NO_SERVER = 2'd3
   } status_type;

   typedef enum logic {
      CSR_SERVER_CODE    = 1'b0,
      CSR_REDUNDANT_CODE = 1'b1
   } csr_index_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_WALK = 1'b1
   } fsm_type;

   // Probe that walks the cell row, one cell per cycle.
   typedef struct packed {
      logic [ID_W-1:0] id;     // id under test for a duplicate
      logic            dup;    // a used entry matched the id
      logic            srv;    // a used entry has a server type code
      logic [ID_W-1:0] cand;   // primary candidate: first nonzero server id
   } token_type;

   // Entry write into the cell row.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [ID_W-1:0]   id;
      logic [KIND_W-1:0] kind;
   } wr_type;

   // Bit t of entry c: the move from mode c to mode t is allowed.
   localparam logic [7:0] ALLOWED_TO [8] = '{
      8'b1100_0010,
      8'b0011_1100,
      8'b0110_1010,
      8'b0000_0001,
      8'b0010_0010,
      8'b0100_0000,
      8'b0000_0011,
      8'b0000_0001
   };

   function automatic logic mode_allowed(input logic [2:0] cur, input logic [2:0] tgt);
      logic [7:0] row;
      row = ALLOWED_TO[cur];
      return row[tgt];
   endfunction

endpackage

>>> src/smnr_if.sv
// ----------------------------------------------------------------------------
// smnr_if - channel interfaces
// Command, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface smnr_req_if;
   import smnr_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          command;
   logic [ID_W-1:0]     node_id;
   logic [KIND_W-1:0]   node_kind;
   logic [2:0]          mode_request;
   logic [ONLINE_W-1:0] online_count;
   logic [ID_W-1:0]     backup_server_id;

   modport source (output valid, command, node_id, node_kind, mode_request,
                   online_count, backup_server_id, input ready);
   modport sink   (input valid, command, node_id, node_kind, mode_request,
                   online_count, backup_server_id, output ready);
endinterface

interface smnr_rsp_if;
   import smnr_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [2:0]          mode_after;
   logic                healthy;
   logic [ID_W-1:0]     primary_server_id;
   logic [RCOUNT_W-1:0] registered_count;

   modport source (output valid, status, mode_after, healthy, primary_server_id,
                   registered_count, input ready);
   modport sink   (input valid, status, mode_after, healthy, primary_server_id,
                   registered_count, output ready);
endinterface

interface smnr_csr_if;
   import smnr_pkg::*;
   logic              valid;
   logic              ready;
   logic              index;
   logic [KIND_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/smnr_cell.sv
// ----------------------------------------------------------------------------
// smnr_cell - one registry entry
// Holds one node id and type code, updates the passing probe and hands it on.
// ----------------------------------------------------------------------------
module smnr_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [smnr_pkg::IDX_W-1:0]  my_idx,
   input  logic [smnr_pkg::CNT_W-1:0]  count,
   input  logic [smnr_pkg::KIND_W-1:0] server_code,
   input  logic [smnr_pkg::KIND_W-1:0] redundant_code,
   input  smnr_pkg::wr_type          wr,
   input  logic                      tok_vld_in,
   input  smnr_pkg::token_type       tok_in,
   output logic                      tok_vld_out,
   output smnr_pkg::token_type       tok_out
);
   import smnr_pkg::*;

   logic [ID_W-1:0]   ent_id_ff;
   logic [KIND_W-1:0] ent_kind_ff;
   logic              tok_vld_ff;
   token_type         tok_ff;
   token_type         tok_in_upd;
   logic              used;
   logic              is_srv;

   assign used   = (CNT_W'(my_idx) < count);
   assign is_srv = (ent_kind_ff == server_code) || (ent_kind_ff == redundant_code);

   always_comb begin
      tok_in_upd = tok_in;
      if (used && (ent_id_ff == tok_in.id)) begin
         tok_in_upd.dup = 1'b1;
      end
      if (used && is_srv) begin
         tok_in_upd.srv = 1'b1;
         if (tok_in.cand == '0) begin
            tok_in_upd.cand = ent_id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == my_idx)) begin
         ent_id_ff   <= wr.id;
         ent_kind_ff <= wr.kind;
      end
      tok_ff <= tok_in_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff <= 1'b0;
      end else begin
         tok_vld_ff <= tok_vld_in;
      end
   end

   assign tok_vld_out = tok_vld_ff;
   assign tok_out     = tok_ff;

endmodule

>>> src/supervisor_mode_and_node_registry.sv
// ----------------------------------------------------------------------------
// supervisor_mode_and_node_registry - supervisory mode controller with registry
// Registers nodes, moves the mode along the transition table, activates with
// primary server latch, answers health queries and requests shutdown.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake      | carries
//   --------+-----+----------------+------------------------------------------
//   req_ch  | in  | valid / ready  | command, node id/kind, mode request, ...
//   rsp_ch  | out | valid / ready  | status, mode, healthy, primary, count
//   csr_ch  | in  | valid / ready  | register index, type code (always ready)
//
// The probe enters the row at the accept edge and moves one cell per cycle
// through the registered cells; the command commits as the probe leaves the
// last cell, and the result register is loaded at that edge.
// One item is in flight at a time. The next item is accepted at the edge that
// takes the result, so a result that waits holds off the next item.
// Reset sets the mode to init, clears node count and primary id and restores
// the type codes to 1 and 2; the registry entries themselves are not cleared,
// only entries below the count are used.
// ----------------------------------------------------------------------------
module supervisor_mode_and_node_registry (
   input  logic       clock,
   input  logic       reset,
   smnr_req_if.sink   req_ch,
   smnr_rsp_if.source rsp_ch,
   smnr_csr_if.sink   csr_ch
);
   import smnr_pkg::*;

   localparam int CMP_W = (CNT_W > ONLINE_W) ? CNT_W : ONLINE_W;
   localparam int PAD_W = CNT_W + RCOUNT_W;

   // Control state
   fsm_type           fsm_ff, fsm_in;
   logic [2:0]        mode_ff, mode_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]   primary_ff, primary_in;
   logic [KIND_W-1:0] server_code_ff, redundant_code_ff;

   // Item held during the walk
   logic [2:0]          cmd_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [2:0]          target_ff;
   logic [ONLINE_W-1:0] online_ff;
   logic [ID_W-1:0]     backup_ff;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [2:0]          rsp_mode_ff;
   logic                rsp_healthy_ff, rsp_healthy_in;
   logic [ID_W-1:0]     rsp_primary_ff;
   logic [RCOUNT_W-1:0] rsp_count_ff;

   logic              req_acc;
   logic              commit;
   wr_type            wr;
   logic [PAD_W-1:0]  count_pad;

   // Cell row
   logic      chain_vld [MAX_NODES+1];
   token_type chain_tok [MAX_NODES+1];

   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (fsm_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign csr_ch.ready = 1'b1;

   // Inject the probe at the head of the row on accept.
   assign chain_vld[0]      = req_acc;
   assign chain_tok[0].id   = req_ch.node_id;
   assign chain_tok[0].dup  = 1'b0;
   assign chain_tok[0].srv  = 1'b0;
   assign chain_tok[0].cand = primary_ff;

   for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
      smnr_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .my_idx         (IDX_W'(g)),
         .count          (count_ff),
         .server_code    (server_code_ff),
         .redundant_code (redundant_code_ff),
         .wr             (wr),
         .tok_vld_in     (chain_vld[g]),
         .tok_in         (chain_tok[g]),
         .tok_vld_out    (chain_vld[g+1]),
         .tok_out        (chain_tok[g+1])
      );
   end

   // Commit when the probe leaves the last cell.
   assign commit = (fsm_ff == FSM_WALK) && chain_vld[MAX_NODES];

   always_comb begin
      fsm_in         = fsm_ff;
      mode_in        = mode_ff;
      count_in       = count_ff;
      primary_in     = primary_ff;
      rsp_status_in  = ST_REJECTED;
      rsp_healthy_in = 1'b0;
      wr.en          = 1'b0;
      wr.idx         = count_ff[IDX_W-1:0];
      wr.id          = chain_tok[MAX_NODES].id;
      wr.kind        = kind_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      unique case (fsm_ff)
         FSM_IDLE: begin
            if (req_acc) begin
               fsm_in = FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (commit) begin
               fsm_in       = FSM_IDLE;
               rsp_valid_in = 1'b1;
               unique case (cmd_ff)
                  CMD_REGISTER: begin
                     if ((count_ff < CNT_W'(MAX_NODES)) && !chain_tok[MAX_NODES].dup) begin
                        wr.en         = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = ST_OK;
                     end
                  end
                  CMD_SET_MODE: begin
                     if (mode_allowed(mode_ff, target_ff)) begin
                        mode_in       = target_ff;
                        rsp_status_in = ST_OK;
                     end
                  end
                  CMD_ACTIVATE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_NO_NODES;
                     end else if (!chain_tok[MAX_NODES].srv) begin
                        rsp_status_in = ST_NO_SERVER;
                     end else begin
                        // latch the primary even when the move to run is refused
                        primary_in = chain_tok[MAX_NODES].cand;
                        if (mode_allowed(mode_ff, MODE_RUN)) begin
                           mode_in       = MODE_RUN;
                           rsp_status_in = ST_OK;
                        end
                     end
                  end
                  CMD_HEALTH: begin
                     rsp_status_in  = ST_OK;
                     rsp_healthy_in = 1'b1;
                     if ((mode_ff == MODE_ESTOP) || (mode_ff == MODE_SHUTDOWN)) begin
                        rsp_healthy_in = 1'b0;
                     end
                     if ((primary_ff == '0) && (backup_ff == '0)) begin
                        rsp_healthy_in = 1'b0;
                     end
                     if (CMP_W'(online_ff) > CMP_W'(count_ff)) begin
                        rsp_healthy_in = 1'b0;
                     end
                  end
                  CMD_SHUTDOWN: begin
                     if (mode_allowed(mode_ff, MODE_SHUTDOWN)) begin
                        mode_in       = MODE_SHUTDOWN;
                        rsp_status_in = ST_OK;
                     end
                  end
                  default: begin
                     // unused command codes: reject, change nothing
                     rsp_status_in = ST_REJECTED;
                  end
               endcase
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   assign count_pad = PAD_W'(count_in);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff            <= FSM_IDLE;
         mode_ff           <= MODE_INIT;
         count_ff          <= '0;
         primary_ff        <= '0;
         server_code_ff    <= KIND_W'(1);
         redundant_code_ff <= KIND_W'(2);
         rsp_valid_ff      <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         primary_ff   <= primary_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               CSR_SERVER_CODE:    server_code_ff    <= csr_ch.data;
               CSR_REDUNDANT_CODE: redundant_code_ff <= csr_ch.data;
               default: ;
            endcase
         end
      end
   end

   // Hold the item fields and the result payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff    <= req_ch.command;
         kind_ff   <= req_ch.node_kind;
         target_ff <= req_ch.mode_request;
         online_ff <= req_ch.online_count;
         backup_ff <= req_ch.backup_server_id;
      end
      if (commit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_mode_ff    <= mode_in;
         rsp_healthy_ff <= rsp_healthy_in;
         rsp_primary_ff <= primary_in;
         rsp_count_ff   <= count_pad[RCOUNT_W-1:0];
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_status_ff;
   assign rsp_ch.mode_after        = rsp_mode_ff;
   assign rsp_ch.healthy           = rsp_healthy_ff;
   assign rsp_ch.primary_server_id = rsp_primary_ff;
   assign rsp_ch.registered_count  = rsp_count_ff;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - supervisor mode controller and node registry
// Drives commands, type code writes and result stalls, and predicts every
// result (status, mode, health verdict, primary id, node count) with a
// cycle-free model of the registry that is held in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
   import smnr_pkg::*;

   localparam int CMD_CODE_MAX   = 7;      // highest code the command field can carry
   localparam int WATCHDOG_LIMIT = 4000;   // cycles without any handshake
   localparam int HOLD_OFF_LEN   = 300;    // long receiver stall that backs up the block
   localparam int DRAIN_CYCLES   = 40;     // block latency plus margin
   localparam int PHASE_ITEMS    = 280;

   typedef struct packed {
      logic [2:0]          command;
      logic [ID_W-1:0]     node_id;
      logic [KIND_W-1:0]   node_kind;
      logic [2:0]          mode_request;
      logic [ONLINE_W-1:0] online_count;
      logic [ID_W-1:0]     backup_server_id;
   } command_item_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [2:0]          mode_after;
      logic                healthy;
      logic [ID_W-1:0]     primary_server_id;
      logic [RCOUNT_W-1:0] registered_count;
   } reply_item_type;

   // Keep a private copy of the supervisor state, predict each reply when its
   // command is accepted, and compare replies in order.
   class registry_predictor_type;
      mode_type          mode;
      logic [ID_W-1:0]   ids [MAX_NODES];
      logic [KIND_W-1:0] kinds [MAX_NODES];
      int unsigned       total;
      logic [ID_W-1:0]   primary;
      logic [KIND_W-1:0] server_code;
      logic [KIND_W-1:0] redundant_code;
      bit [7:0]          legal [8];
      reply_item_type    expected_replies [$];
      int unsigned       mismatches;

      function new();
         legal[MODE_INIT]     = (8'd1 << MODE_RUN) | (8'd1 << MODE_MAINT) | (8'd1 << MODE_SIM);
         legal[MODE_RUN]      = (8'd1 << MODE_HOLD) | (8'd1 << MODE_SHUTDOWN) |
                                (8'd1 << MODE_FAILOVER) | (8'd1 << MODE_ESTOP);
         legal[MODE_HOLD]     = (8'd1 << MODE_RUN) | (8'd1 << MODE_SHUTDOWN) |
                                (8'd1 << MODE_ESTOP) | (8'd1 << MODE_MAINT);
         legal[MODE_SHUTDOWN] = (8'd1 << MODE_INIT);
         legal[MODE_FAILOVER] = (8'd1 << MODE_RUN) | (8'd1 << MODE_ESTOP);
         legal[MODE_ESTOP]    = (8'd1 << MODE_MAINT);
         legal[MODE_MAINT]    = (8'd1 << MODE_INIT) | (8'd1 << MODE_RUN);
         legal[MODE_SIM]      = (8'd1 << MODE_INIT);
         mode           = MODE_INIT;
         total          = 0;
         primary        = '0;
         server_code    = 4'd1;
         redundant_code = 4'd2;
         mismatches     = 0;
      endfunction

      function logic [1:0] try_move(logic [2:0] target);
         if (!legal[mode][target])
            return ST_REJECTED;
         mode = mode_type'(target);
         return ST_OK;
      endfunction

      function void set_type_code(csr_index_type index, logic [KIND_W-1:0] value);
         if (index == CSR_SERVER_CODE)
            server_code = value;
         else
            redundant_code = value;
      endfunction

      function void note_command(command_item_type it);
         reply_item_type exp;
         bit             dup;
         bit             has_server;
         exp.status  = ST_REJECTED;
         exp.healthy = 1'b0;
         case (it.command)
            CMD_REGISTER: begin
               if (total < MAX_NODES) begin
                  dup = 1'b0;
                  for (int i = 0; i < total; i++)
                     if (ids[i] == it.node_id)
                        dup = 1'b1;
                  if (!dup) begin
                     ids[total]   = it.node_id;
                     kinds[total] = it.node_kind;
                     total++;
                     exp.status   = ST_OK;
                  end
               end
            end
            CMD_SET_MODE: exp.status = try_move(it.mode_request);
            CMD_ACTIVATE: begin
               if (total == 0) begin
                  exp.status = ST_NO_NODES;
               end else begin
                  // latch the first server entry; a zero id counts as no primary
                  has_server = 1'b0;
                  for (int i = 0; i < total; i++)
                     if (kinds[i] == server_code || kinds[i] == redundant_code) begin
                        has_server = 1'b1;
                        if (primary == '0)
                           primary = ids[i];
                     end
                  exp.status = has_server ? try_move(MODE_RUN) : ST_NO_SERVER;
               end
            end
            CMD_HEALTH: begin
               exp.status  = ST_OK;
               exp.healthy = !(mode == MODE_ESTOP || mode == MODE_SHUTDOWN) &&
                             !(primary == '0 && it.backup_server_id == '0) &&
                             !(it.online_count > total);
            end
            CMD_SHUTDOWN: exp.status = try_move(MODE_SHUTDOWN);
            default: ;
         endcase
         exp.mode_after        = mode;
         exp.primary_server_id = primary;
         exp.registered_count  = RCOUNT_W'(total);
         expected_replies.push_back(exp);
      endfunction

      function void check_reply(reply_item_type got);
         reply_item_type exp;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: status %0d mode %0d healthy %0b primary %h count %0d",
                        got.status, got.mode_after, got.healthy, got.primary_server_id,
                        got.registered_count);
            return;
         end
         exp = expected_replies.pop_front();
         if (got.status !== exp.status || got.mode_after !== exp.mode_after ||
             got.healthy !== exp.healthy || got.primary_server_id !== exp.primary_server_id ||
             got.registered_count !== exp.registered_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("reply mismatch at %0t", $realtime);
               $display("  expected: status %0d mode %0d healthy %0b primary %h count %0d",
                        exp.status, exp.mode_after, exp.healthy, exp.primary_server_id,
                        exp.registered_count);
               $display("  actual:   status %0d mode %0d healthy %0b primary %h count %0d",
                        got.status, got.mode_after, got.healthy, got.primary_server_id,
                        got.registered_count);
            end
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function bit clean();
         return mismatches == 0 && expected_replies.size() == 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   smnr_req_if req_ch ();
   smnr_rsp_if rsp_ch ();
   smnr_csr_if csr_ch ();

   supervisor_mode_and_node_registry u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   registry_predictor_type registry = new();
   command_item_type       directed [$];
   int unsigned            quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result sink: check every accepted reply, then pick the next ready value.
   // Switch between always ready, random stalls and a rotating mask on its own
   // schedule; twice hold off for a long stretch so that the block backs up
   // and stalls the command channel while the sender keeps offering items.
   initial begin : reply_sink
      reply_item_type got;
      int unsigned    taken;
      int unsigned    hold_left;
      int unsigned    style_left;
      int unsigned    style;
      logic [7:0]     mask;
      rsp_ch.ready = 1'b0;
      taken        = 0;
      hold_left    = 0;
      style_left   = 0;
      style        = 0;
      mask         = 8'hff;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status            = rsp_ch.status;
            got.mode_after        = rsp_ch.mode_after;
            got.healthy           = rsp_ch.healthy;
            got.primary_server_id = rsp_ch.primary_server_id;
            got.registered_count  = rsp_ch.registered_count;
            registry.check_reply(got);
            taken++;
            if (taken == 400 || taken == 1100)
               hold_left = HOLD_OFF_LEN;
         end
         if (style_left == 0) begin
            style      = $urandom_range(0, 2);
            style_left = $urandom_range(16, 128);
            mask       = 8'($urandom) | 8'h01;
         end else begin
            style_left--;
         end
         mask = {mask[6:0], mask[7]};
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (style)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= mask[0];
            endcase
         end
      end
   end

   function automatic command_item_type pack_item(logic [2:0] command, logic [ID_W-1:0] id,
                                                  logic [KIND_W-1:0] kind, logic [2:0] target,
                                                  logic [ONLINE_W-1:0] online,
                                                  logic [ID_W-1:0] backup);
      command_item_type it;
      it.command          = command;
      it.node_id          = id;
      it.node_kind        = kind;
      it.mode_request     = target;
      it.online_count     = online;
      it.backup_server_id = backup;
      return it;
   endfunction

   // Build a random command from the current predicted state: reuse known ids
   // to hit duplicates, favor server type codes, and steer most mode requests
   // toward moves that the table allows so that every mode gets visited.
   function automatic command_item_type random_item();
      command_item_type it;
      int unsigned      pick;
      logic [2:0]       options [$];
      it.command          = CMD_HEALTH;
      it.node_id          = $urandom;
      it.node_kind        = KIND_W'($urandom_range(0, 15));
      it.mode_request     = 3'($urandom_range(0, 7));
      it.online_count     = ONLINE_W'($urandom_range(0, 64));
      it.backup_server_id = ($urandom_range(0, 3) == 0) ? '0 : ID_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         it.command = CMD_REGISTER;
         if (registry.total != 0 && $urandom_range(0, 3) == 0)
            it.node_id = registry.ids[$urandom_range(0, registry.total - 1)];
         else if ($urandom_range(0, 19) == 0)
            it.node_id = '0;
         if ($urandom_range(0, 9) < 4)
            it.node_kind = $urandom_range(0, 1) ? registry.server_code : registry.redundant_code;
      end else if (pick < 55) begin
         it.command = CMD_SET_MODE;
         if ($urandom_range(0, 9) < 6) begin
            for (int t = 0; t < 8; t++)
               if (registry.legal[registry.mode][t])
                  options.push_back(t[2:0]);
            it.mode_request = options[$urandom_range(0, options.size() - 1)];
         end
      end else if (pick < 65) begin
         it.command = CMD_ACTIVATE;
      end else if (pick < 82) begin
         it.command = CMD_HEALTH;
         if ($urandom_range(0, 9) < 7)
            it.online_count = ONLINE_W'($urandom_range(0, (registry.total < 64) ?
                                                          registry.total + 1 : 64));
      end else if (pick < 92) begin
         it.command = CMD_SHUTDOWN;
      end else begin
         it.command = 3'($urandom_range(CMD_CODE_MAX, int'(CMD_SHUTDOWN) + 1));
      end
      return it;
   endfunction

   // Write one type code register; call at a rising edge with the block idle.
   task automatic write_type_code(input csr_index_type index, input logic [KIND_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      registry.set_type_code(index, value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Send count items (directed ones first while any remain), in bursts with
   // gaps when bursty is set, then drop valid and wait for every reply.
   task automatic run_phase(input int unsigned count, input bit bursty);
      command_item_type it;
      int unsigned      burst_left;
      int unsigned      gap;
      burst_left = $urandom_range(1, 24);
      for (int unsigned n = 0; n < count; n++) begin
         it  = (directed.size() != 0) ? directed.pop_front() : random_item();
         gap = 0;
         if (bursty) begin
            if (burst_left == 0) begin
               gap        = $urandom_range(1, 12);
               burst_left = $urandom_range(1, 24);
            end else begin
               burst_left--;
            end
         end
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid            <= 1'b1;
         req_ch.command          <= it.command;
         req_ch.node_id          <= it.node_id;
         req_ch.node_kind        <= it.node_kind;
         req_ch.mode_request     <= it.mode_request;
         req_ch.online_count     <= it.online_count;
         req_ch.backup_server_id <= it.backup_server_id;
         do @(posedge clock); while (!req_ch.ready);
         registry.note_command(it);
      end
      req_ch.valid <= 1'b0;
      while (registry.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [KIND_W-1:0] server_value;
      logic [KIND_W-1:0] redundant_value;
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.command          = CMD_REGISTER;
      req_ch.node_id          = '0;
      req_ch.node_kind        = '0;
      req_ch.mode_request     = MODE_INIT;
      req_ch.online_count     = '0;
      req_ch.backup_server_id = '0;
      csr_ch.valid            = 1'b0;
      csr_ch.index            = CSR_SERVER_CODE;
      csr_ch.data             = '0;

      // Directed opening with the reset type codes (server 1, redundant 2):
      // health before any primary or backup, activate on an empty registry,
      // an unused command, a duplicate id, activate with no server node,
      // online count above the registry size, a server with id zero that
      // latches nothing, a later server that latches while the run request
      // itself is refused, then a walk over the mode table.
      directed.push_back(pack_item(CMD_HEALTH, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_ACTIVATE, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(3'(CMD_CODE_MAX), '1, 4'd15, MODE_SIM, 7'd64, '1));
      directed.push_back(pack_item(CMD_REGISTER, '1, 4'd15, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_REGISTER, '1, 4'd0, MODE_SIM, 7'd0, '0));
      directed.push_back(pack_item(CMD_ACTIVATE, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_HEALTH, '0, 4'd0, MODE_INIT, 7'd1, '1));
      directed.push_back(pack_item(CMD_HEALTH, '0, 4'd0, MODE_INIT, 7'd64, 32'd1));
      directed.push_back(pack_item(CMD_REGISTER, '0, 4'd1, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_ACTIVATE, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_HEALTH, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_REGISTER, 32'h8000_0001, 4'd2, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_ACTIVATE, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_HOLD, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_SIM, 7'd0, '0));
      directed.push_back(pack_item(CMD_SHUTDOWN, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_HEALTH, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_RUN, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_SIM, 7'd0, '0));
      directed.push_back(pack_item(CMD_SHUTDOWN, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_INIT, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_MAINT, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_RUN, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_FAILOVER, 7'd0, '0));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_ESTOP, 7'd0, '0));
      directed.push_back(pack_item(CMD_HEALTH, '0, 4'd0, MODE_INIT, 7'd0, 32'd5));
      directed.push_back(pack_item(CMD_SET_MODE, '0, 4'd0, MODE_MAINT, 7'd0, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_phase(directed.size(), 1'b1);

      // Random phases, each behind a fresh pair of type codes: both extremes
      // in each order, random pairs, both codes equal, and the reset pair.
      // Hold the third phase free of sender gaps.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       begin server_value = 4'd0;  redundant_value = 4'd15; end
            1:       begin server_value = 4'd15; redundant_value = 4'd0;  end
            3:       begin server_value = 4'd7;  redundant_value = 4'd7;  end
            4:       begin server_value = 4'd1;  redundant_value = 4'd2;  end
            default: begin
               server_value    = KIND_W'($urandom_range(0, 15));
               redundant_value = KIND_W'($urandom_range(0, 15));
            end
         endcase
         write_type_code(CSR_SERVER_CODE, server_value);
         write_type_code(CSR_REDUNDANT_CODE, redundant_value);
         run_phase(PHASE_ITEMS, phase != 2);
      end

      // Let any stray reply surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (registry.clean())
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
